// File: rtl/quad_x_motor_mixer_top_assert.svh
// Assertion macros shared by the mixer checker.
`ifndef QUAD_X_MOTOR_MIXER_TOP_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QXM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QXM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/qxm_pkg.sv
// Shared constants, types and mixing table of the quad-X motor mixer.
package qxm_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int AXIS_LIMIT = 500;
	localparam int ONE        = 1 << FRAC_BITS;

	localparam int CMD_W  = 16;
	localparam int OUT_W  = 13;
	localparam int LVL_W  = FRAC_BITS + 1;
	// magnitude of a command times one half
	localparam int NUM_W  = CMD_W + FRAC_BITS - 1;
	localparam int REC_W  = NUM_W + 1;
	localparam logic [REC_W-1:0] REC = REC_W'((64'd1 << NUM_W) / AXIS_LIMIT);
	localparam int PROD_W = NUM_W + REC_W;
	localparam int Q_W    = NUM_W + 1;
	localparam int MIX_W  = Q_W + 2;
	localparam int ADJ_W  = MIX_W + 2;

	localparam int NMOT     = 4;
	// clock edges from the accepting edge to the edge that takes the result
	localparam int PIPE_LAT = 8;

	// register port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-3:0] REG_IDLE_LEVEL = '0;

	// minus signs per motor: bit 0 roll, bit 1 pitch, bit 2 yaw
	// order: front right, front left, rear right, rear left
	localparam logic [2:0] MIX_NEG [NMOT] = '{3'b010, 3'b111, 3'b100, 3'b001};

	typedef logic signed [Q_W-1:0] axis_t;
	typedef logic [LVL_W-1:0] lvl_t;

	typedef struct packed {
		lvl_t  thr;
		axis_t roll;
		axis_t pitch;
		axis_t yaw;
	} mix_in_t;

endpackage

// File: rtl/qxm_scale.sv
// One axis lane: scale a command by ONE/2/AXIS_LIMIT, truncated toward zero.
module qxm_scale (
	input  logic                           clk,
	input  logic signed [qxm_pkg::CMD_W-1:0] cmd,
	output qxm_pkg::axis_t                 val_s4
);
	import qxm_pkg::*;

	logic [CMD_W-1:0]  mag;
	logic [NUM_W-1:0]  num_s1, num_s2;
	logic              neg_s1, neg_s2, neg_s3;
	logic [PROD_W-1:0] prod;
	logic [NUM_W-1:0]  qest_s2, qest_s3;
	logic [NUM_W-1:0]  qd;
	logic [NUM_W-1:0]  rem_s3;
	logic [NUM_W-1:0]  qfix;

	// magnitude of the command
	assign mag = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);

	// reciprocal estimate, may be one short
	assign prod = PROD_W'(num_s1) * PROD_W'(REC);

	// estimate times AXIS_LIMIT, subtracted to form the remainder
	assign qd = NUM_W'(qest_s2 * NUM_W'(AXIS_LIMIT));

	// correct the estimate by one
	assign qfix = qest_s3 + NUM_W'(rem_s3 >= NUM_W'(AXIS_LIMIT));

	always_ff @(posedge clk) begin
		num_s1  <= NUM_W'(mag) << (FRAC_BITS - 1);
		neg_s1  <= cmd[CMD_W-1];
		qest_s2 <= prod[2*NUM_W-1:NUM_W];
		num_s2  <= num_s1;
		neg_s2  <= neg_s1;
		qest_s3 <= qest_s2;
		rem_s3  <= num_s2 - qd;
		neg_s3  <= neg_s2;
		val_s4  <= neg_s3 ? -signed'({1'b0, qfix}) : signed'({1'b0, qfix});
	end

endmodule

// File: rtl/qxm_front.sv
// Front stages: throttle clamp and the three axis scaling lanes.
module qxm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic signed [qxm_pkg::CMD_W-1:0] throttle,
	input  logic signed [qxm_pkg::CMD_W-1:0] roll_cmd,
	input  logic signed [qxm_pkg::CMD_W-1:0] pitch_cmd,
	input  logic signed [qxm_pkg::CMD_W-1:0] yaw_cmd,
	output logic                             vld_s4,
	output qxm_pkg::mix_in_t                 item_s4
);
	import qxm_pkg::*;

	logic  vld_s1, vld_s2, vld_s3;
	lvl_t  thr_c;
	lvl_t  thr_s1, thr_s2, thr_s3, thr_s4;
	axis_t roll_s4, pitch_s4, yaw_s4;

	// clamp throttle to 0..ONE
	always_comb begin
		if (throttle < 0) begin
			thr_c = '0;
		end else if (throttle > ONE) begin
			thr_c = LVL_W'(ONE);
		end else begin
			thr_c = LVL_W'(throttle);
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// carry throttle alongside the scaling lanes
	always_ff @(posedge clk) begin
		thr_s1 <= thr_c;
		thr_s2 <= thr_s1;
		thr_s3 <= thr_s2;
		thr_s4 <= thr_s3;
	end

	qxm_scale u_roll  (.clk(clk), .cmd(roll_cmd),  .val_s4(roll_s4));
	qxm_scale u_pitch (.clk(clk), .cmd(pitch_cmd), .val_s4(pitch_s4));
	qxm_scale u_yaw   (.clk(clk), .cmd(yaw_cmd),   .val_s4(yaw_s4));

	assign item_s4.thr   = thr_s4;
	assign item_s4.roll  = roll_s4;
	assign item_s4.pitch = pitch_s4;
	assign item_s4.yaw   = yaw_s4;

endmodule

// File: rtl/qxm_mix.sv
// Back stages: sign matrix, min/max, desaturation shift and final clamp.
module qxm_mix (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  qxm_pkg::mix_in_t         item,
	input  logic [qxm_pkg::OUT_W-1:0] idle,
	output logic                     vld_s8,
	output logic [qxm_pkg::OUT_W-1:0] motor_s8 [qxm_pkg::NMOT]
);
	import qxm_pkg::*;

	localparam logic signed [MIX_W-1:0] ONE_MIX = MIX_W'(ONE);
	localparam logic signed [ADJ_W-1:0] ONE_ADJ = ADJ_W'(ONE);

	logic vld_s5, vld_s6, vld_s7;

	logic signed [MIX_W-1:0] thr_e, roll_e, pitch_e, yaw_e;
	logic signed [MIX_W-1:0] sum_c [NMOT];
	logic signed [MIX_W-1:0] m_s5 [NMOT];
	logic signed [MIX_W-1:0] m_s6 [NMOT];
	logic signed [MIX_W-1:0] m_s7 [NMOT];
	logic signed [MIX_W-1:0] lo_a, lo_b, hi_a, hi_b;
	logic signed [MIX_W-1:0] mn_s6, mx_s6;
	logic signed [ADJ_W-1:0] down_c, up_c;
	logic signed [ADJ_W-1:0] off_s7;
	logic signed [ADJ_W-1:0] idle_ext, idle_eff;
	logic signed [ADJ_W-1:0] v_c [NMOT];
	logic signed [ADJ_W-1:0] cl_c [NMOT];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s5 <= in_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// mix through the quad-X sign matrix
	always_comb begin
		thr_e   = signed'(MIX_W'({1'b0, item.thr}));
		roll_e  = MIX_W'(signed'(item.roll));
		pitch_e = MIX_W'(signed'(item.pitch));
		yaw_e   = MIX_W'(signed'(item.yaw));
		for (int i = 0; i < NMOT; i++) begin
			sum_c[i] = thr_e
				+ (MIX_NEG[i][0] ? -roll_e  : roll_e)
				+ (MIX_NEG[i][1] ? -pitch_e : pitch_e)
				+ (MIX_NEG[i][2] ? -yaw_e   : yaw_e);
		end
	end

	// minimum and maximum over the four raw values
	always_comb begin
		lo_a = (m_s5[0] < m_s5[1]) ? m_s5[0] : m_s5[1];
		lo_b = (m_s5[2] < m_s5[3]) ? m_s5[2] : m_s5[3];
		hi_a = (m_s5[0] > m_s5[1]) ? m_s5[0] : m_s5[1];
		hi_b = (m_s5[2] > m_s5[3]) ? m_s5[2] : m_s5[3];
	end

	// shift down by the excess over ONE, up by the magnitude of the minimum
	always_comb begin
		down_c = (mx_s6 > ONE_MIX) ? ADJ_W'(mx_s6 - ONE_MIX) : '0;
		up_c   = (mn_s6 < 0) ? -ADJ_W'(mn_s6) : '0;
	end

	// apply the shift and clamp to idle..ONE
	always_comb begin
		idle_ext = signed'(ADJ_W'(idle));
		idle_eff = (idle_ext > ONE_ADJ) ? ONE_ADJ : idle_ext;
		for (int i = 0; i < NMOT; i++) begin
			v_c[i] = ADJ_W'(m_s7[i]) + off_s7;
			if (v_c[i] < idle_eff) begin
				cl_c[i] = idle_eff;
			end else if (v_c[i] > ONE_ADJ) begin
				cl_c[i] = ONE_ADJ;
			end else begin
				cl_c[i] = v_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		m_s5   <= sum_c;
		m_s6   <= m_s5;
		mn_s6  <= (lo_a < lo_b) ? lo_a : lo_b;
		mx_s6  <= (hi_a > hi_b) ? hi_a : hi_b;
		m_s7   <= m_s6;
		off_s7 <= up_c - down_c;
		for (int i = 0; i < NMOT; i++) begin
			motor_s8[i] <= OUT_W'(cl_c[i]);
		end
	end

endmodule

// File: rtl/quad_x_motor_mixer_top.sv
// Top level of the quad-X motor mixer with desaturation.
//
//  channel  | direction | handshake                         | payload
//  ---------+-----------+-----------------------------------+-------------------------------
//  command  | in        | start high, busy low              | throttle, roll/pitch/yaw_cmd
//  result   | out       | done, one cycle, no back-pressure | motor_front/rear_right/left
//  register | in/out    | APB write when psel&penable&pwrite| idle_level at byte address 0
//
// An item may be taken on every clock; busy stays low.
// Eight register stages, s1 to s8, lie between the accepting edge and done.
// The scaling lane (reciprocal multiply, then remainder correction) sets the front depth.
// arst_n clears the valid bits and idle_level; data stages carry no reset.
// The receiver cannot stall, so results never wait in the pipeline.
module quad_x_motor_mixer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [qxm_pkg::CMD_W-1:0]  throttle,
	input  logic signed [qxm_pkg::CMD_W-1:0]  roll_cmd,
	input  logic signed [qxm_pkg::CMD_W-1:0]  pitch_cmd,
	input  logic signed [qxm_pkg::CMD_W-1:0]  yaw_cmd,
	output logic                              done,
	output logic [qxm_pkg::OUT_W-1:0]         motor_front_right,
	output logic [qxm_pkg::OUT_W-1:0]         motor_front_left,
	output logic [qxm_pkg::OUT_W-1:0]         motor_rear_right,
	output logic [qxm_pkg::OUT_W-1:0]         motor_rear_left,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [qxm_pkg::ADDR_W-1:0]        paddr,
	input  logic [qxm_pkg::DATA_W-1:0]        pwdata,
	output logic [qxm_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import qxm_pkg::*;

	logic [OUT_W-1:0] idle_level_q;
	logic             vld_s4;
	mix_in_t          item_s4;
	logic [OUT_W-1:0] motor_s8 [NMOT];
	logic             reg_wr;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// decode register write
	assign reg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_IDLE_LEVEL);

	// hold idle level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q <= '0;
		end else if (reg_wr) begin
			idle_level_q <= pwdata[OUT_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_IDLE_LEVEL) begin
			prdata = DATA_W'(idle_level_q);
		end
	end

	qxm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start && !busy),
		.throttle  (throttle),
		.roll_cmd  (roll_cmd),
		.pitch_cmd (pitch_cmd),
		.yaw_cmd   (yaw_cmd),
		.vld_s4    (vld_s4),
		.item_s4   (item_s4)
	);

	qxm_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.item     (item_s4),
		.idle     (idle_level_q),
		.vld_s8   (done),
		.motor_s8 (motor_s8)
	);

	assign motor_front_right = motor_s8[0];
	assign motor_front_left  = motor_s8[1];
	assign motor_rear_right  = motor_s8[2];
	assign motor_rear_left   = motor_s8[3];

endmodule

// File: rtl/qxm_checker.sv
// Port-level checker for the mixer, bound to the top level.
`include "quad_x_motor_mixer_top_assert.svh"

module qxm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [qxm_pkg::OUT_W-1:0]  motor_front_right,
	input logic [qxm_pkg::OUT_W-1:0]  motor_front_left,
	input logic [qxm_pkg::OUT_W-1:0]  motor_rear_right,
	input logic [qxm_pkg::OUT_W-1:0]  motor_rear_left,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [qxm_pkg::ADDR_W-1:0] paddr,
	input logic [qxm_pkg::DATA_W-1:0] pwdata,
	input logic [qxm_pkg::DATA_W-1:0] prdata,
	input logic                       pready
);
	import qxm_pkg::*;

	logic motors_ok;
	logic idle_sel;
	logic idle_wr;

	assign motors_ok = (motor_front_right <= OUT_W'(ONE)) && (motor_front_left <= OUT_W'(ONE))
		&& (motor_rear_right <= OUT_W'(ONE)) && (motor_rear_left <= OUT_W'(ONE));
	assign idle_sel  = (paddr[ADDR_W-1:2] == REG_IDLE_LEVEL);
	assign idle_wr   = psel && penable && pwrite && idle_sel;

	// every accepted item yields a result after the fixed latency
	`QXM_ASSERT_NXT(a_lat_fwd, start && !busy, ##(PIPE_LAT-1) done, "result missing after item")

	// no result without an item accepted at the fixed latency before
	`QXM_ASSERT_IMP(a_lat_back, done, $past(start && !busy, PIPE_LAT), "result without item")

	// outputs never exceed full scale
	`QXM_ASSERT_IMP(a_range, done, motors_ok, "motor above full scale")

	// a written idle level reads back on the next cycle
	`QXM_ASSERT_IMP(a_readback, idle_wr ##1 idle_sel, prdata[OUT_W-1:0] == $past(pwdata[OUT_W-1:0]), "idle readback")

	// register port never waits
	`QXM_ASSERT_IMP(a_pready, psel, pready, "pready low during transfer")

endmodule

bind quad_x_motor_mixer_top qxm_checker u_qxm_checker (.*);
